@@ sv/bal_pkg.sv @@
// bal_pkg: widths and constants shared by the cubic Bezier arc length blocks.
// No dependencies.
`default_nettype none
package bal_pkg;
    localparam int COORD_W        = 24;
    localparam int LEN_W          = 32;
    // chords per curve; must be a power of two, points divide by SEGMENTS^3 with a shift
    localparam int SEGMENTS       = 64;
    localparam int FRAC_BITS_DEF  = 12;
    // each point delta fits in 26 signed bits; squared sums fit in 52 bits
    localparam int DELTA_W        = 26;
    localparam int SQ_W           = 2 * DELTA_W;
    localparam int ROOT_W         = SQ_W / 2 + 1;
endpackage
`default_nettype wire

@@ sv/bal_eval.sv @@
// bal_eval: walks one curve segment per cycle while adv is high and emits chord deltas.
// Depends on bal_pkg.
`default_nettype none
module bal_eval
    import bal_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic signed [COORD_W-1:0] px [4],
    input  wire logic signed [COORD_W-1:0] py [4],
    input  wire logic                      adv,
    output logic                           d_valid,
    output logic                           d_last,
    output logic signed [DELTA_W-1:0]      dx,
    output logic signed [DELTA_W-1:0]      dy
);
    localparam int KW = $clog2(SEGMENTS + 1);
    // forward differences on exact numerators scaled by S^3 (S up to 1024)
    localparam int NW = COORD_W + 36;
    localparam longint S  = SEGMENTS;
    localparam longint S3 = S * S * S;

    logic                 busy_reg, busy_next;
    logic [KW-1:0]        k_reg, k_next;
    logic signed [NW-1:0] vx_reg[3], vy_reg[3];
    logic signed [NW-1:0] fx_reg, fy_reg;
    logic signed [COORD_W+1:0] prx_reg, pry_reg;
    logic                 take;

    function automatic logic signed [NW-1:0] round_pt(input logic signed [NW-1:0] n);
        logic signed [NW-1:0] t;
        t = n + NW'(S3 / 2);
        return t >>> $clog2(S3);
    endfunction

    // initial forward differences of the numerator polynomial
    function automatic void init_fd(input logic signed [COORD_W-1:0] p[4],
                                    output logic signed [NW-1:0] f0,
                                    output logic signed [NW-1:0] d[3]);
        logic signed [NW-1:0] a, b, c;
        c = NW'(3) * (NW'(p[1]) - NW'(p[0]));
        b = NW'(3) * (NW'(p[2]) - NW'(p[1])) - c;
        a = NW'(p[3]) - NW'(p[0]) - c - b;
        f0 = NW'(p[0]) * NW'(S3);
        d[0] = a + b * NW'(S) + c * NW'(S * S);
        d[1] = NW'(6) * a + NW'(2) * b * NW'(S);
        d[2] = NW'(6) * a;
    endfunction

    logic signed [NW-1:0] ifx, ify, ndx, ndy;
    logic signed [NW-1:0] idx[3], idy[3];
    logic signed [NW-1:0] rx, ry;
    always_comb
    begin
        init_fd(px, ifx, idx);
        init_fd(py, ify, idy);
        ndx = fx_reg + vx_reg[0];
        ndy = fy_reg + vy_reg[0];
        rx  = round_pt(ndx);
        ry  = round_pt(ndy);
    end

    // next curve is taken while the last chord leaves
    assign in_ready = !busy_reg || (d_last && adv);
    assign take     = in_valid && in_ready;
    assign d_valid  = busy_reg;
    assign d_last   = (k_reg == KW'(SEGMENTS));
    assign dx = DELTA_W'(rx) - DELTA_W'(prx_reg);
    assign dy = DELTA_W'(ry) - DELTA_W'(pry_reg);

    always_comb
    begin
        busy_next = busy_reg;
        k_next    = k_reg;
        if (take)
        begin
            busy_next = 1'b1;
            k_next    = KW'(1);
        end
        else if (busy_reg && adv)
        begin
            if (d_last)
                busy_next = 1'b0;
            k_next = k_reg + KW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            k_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            k_reg    <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            fx_reg <= ifx;
            fy_reg <= ify;
            vx_reg <= idx;
            vy_reg <= idy;
            prx_reg <= (COORD_W+2)'(px[0]);
            pry_reg <= (COORD_W+2)'(py[0]);
        end
        else if (busy_reg && adv)
        begin
            fx_reg <= ndx;
            fy_reg <= ndy;
            vx_reg[0] <= vx_reg[0] + vx_reg[1];
            vx_reg[1] <= vx_reg[1] + vx_reg[2];
            vy_reg[0] <= vy_reg[0] + vy_reg[1];
            vy_reg[1] <= vy_reg[1] + vy_reg[2];
            prx_reg <= (COORD_W+2)'(rx);
            pry_reg <= (COORD_W+2)'(ry);
        end
    end
endmodule
`default_nettype wire

@@ sv/bal_sqrt.sv @@
// bal_sqrt: pipelined rounded square root, two result bits per stage.
// Depends on bal_pkg.
`default_nettype none
module bal_sqrt
    import bal_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              adv,
    input  wire logic              i_valid,
    input  wire logic              i_last,
    input  wire logic [SQ_W-1:0]   i_sq,
    output logic                   o_valid,
    output logic                   o_last,
    output logic [ROOT_W-1:0]      o_root
);
    localparam int NB = SQ_W / 2;       // result bits
    localparam int ST = NB / 2;         // stages, two bits each
    localparam int RW = SQ_W + 2;

    logic            v_reg[ST+1];
    logic            l_reg[ST+1];
    logic [SQ_W-1:0] n_reg[ST+1];
    logic [RW-1:0]   r_reg[ST+1];
    logic [NB-1:0]   q_reg[ST+1];

    always_comb
    begin
        v_reg[0] = i_valid;
        l_reg[0] = i_last;
        n_reg[0] = i_sq;
        r_reg[0] = '0;
        q_reg[0] = '0;
    end

    for (genvar s = 0; s < ST; s++)
    begin : g_st
        logic [RW-1:0] r1, r2, t;
        logic [NB-1:0] q1, q2;
        always_comb
        begin
            r1 = {r_reg[s][RW-3:0], n_reg[s][SQ_W-1-4*s -: 2]};
            t  = RW'({q_reg[s], 2'b01});
            if (r1 >= t) begin r1 = r1 - t; q1 = {q_reg[s][NB-2:0], 1'b1}; end
            else q1 = {q_reg[s][NB-2:0], 1'b0};
            r2 = {r1[RW-3:0], n_reg[s][SQ_W-3-4*s -: 2]};
            t  = RW'({q1, 2'b01});
            if (r2 >= t) begin r2 = r2 - t; q2 = {q1[NB-2:0], 1'b1}; end
            else q2 = {q1[NB-2:0], 1'b0};
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) v_reg[s+1] <= 1'b0;
            else if (adv) v_reg[s+1] <= v_reg[s];
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                l_reg[s+1] <= l_reg[s];
                n_reg[s+1] <= n_reg[s];
                r_reg[s+1] <= r2;
                q_reg[s+1] <= q2;
            end
        end
    end

    assign o_valid = v_reg[ST];
    assign o_last  = l_reg[ST];
    // remainder above root means round up
    assign o_root  = ROOT_W'(q_reg[ST]) + ROOT_W'(r_reg[ST] > RW'(q_reg[ST]));
endmodule
`default_nettype wire

@@ sv/bezier_arc_length.sv @@
// Cubic Bezier arc length by chord polyline.
// The point walker produces one chord per cycle while the pipe advances, and takes
// the next curve as its last chord leaves. Delta, square, 13-stage square root and
// accumulator keep pace; a held result beat stalls the whole pipe.
// Reset (rst_n, async low) clears all valid and busy state, the chord counter and
// the accumulator; no other data is cleared.
`default_nettype none
module bezier_arc_length
    import bal_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic signed [COORD_W-1:0] start_x,
    input  wire logic signed [COORD_W-1:0] ctrl1_x,
    input  wire logic signed [COORD_W-1:0] ctrl2_x,
    input  wire logic signed [COORD_W-1:0] end_x,
    input  wire logic signed [COORD_W-1:0] start_y,
    input  wire logic signed [COORD_W-1:0] ctrl1_y,
    input  wire logic signed [COORD_W-1:0] ctrl2_y,
    input  wire logic signed [COORD_W-1:0] end_y,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [LEN_W-1:0]               arc_length,
    output logic                           saturated
);
    // FRAC_BITS names the shared coordinate scale and widens the sum only above 64; math is scale free
    localparam int SUM_W = LEN_W + 12 + (FRAC_BITS > 64 ? 1 : 0);

    logic signed [COORD_W-1:0] px[4], py[4];
    assign px = '{start_x, ctrl1_x, ctrl2_x, end_x};
    assign py = '{start_y, ctrl1_y, ctrl2_y, end_y};

    logic adv;
    logic ev_valid, ev_last;
    logic signed [DELTA_W-1:0] dx, dy;
    logic d_valid_reg, d_last_reg;
    logic signed [DELTA_W-1:0] dx_reg, dy_reg;
    logic signed [SQ_W-1:0] dx_sq, dy_sq;
    logic sq_valid_reg, sq_last_reg;
    logic [SQ_W-1:0] sq_reg;
    logic rt_valid, rt_last;
    logic [ROOT_W-1:0] root;
    logic [SUM_W-1:0] acc_reg;
    logic out_valid_reg;
    logic [LEN_W-1:0] len_reg;
    logic sat_reg;

    // whole pipe moves when output slot is free or being drained
    assign adv = !out_valid_reg || out_ready;

    bal_eval u_eval (
        .clk, .rst_n, .in_valid, .in_ready, .px, .py, .adv,
        .d_valid(ev_valid), .d_last(ev_last), .dx, .dy
    );

    // chord deltas, registered ahead of the squares
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) d_valid_reg <= 1'b0;
        else if (adv) d_valid_reg <= ev_valid;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_last_reg <= ev_last;
            dx_reg <= dx;
            dy_reg <= dy;
        end
    end

    // full-width products; deltas are sign extended before the multiply
    assign dx_sq = SQ_W'(dx_reg) * SQ_W'(dx_reg);
    assign dy_sq = SQ_W'(dy_reg) * SQ_W'(dy_reg);

    // chord square, registered ahead of the root pipe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) sq_valid_reg <= 1'b0;
        else if (adv) sq_valid_reg <= d_valid_reg;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_last_reg <= d_last_reg;
            sq_reg <= $unsigned(dx_sq) + $unsigned(dy_sq);
        end
    end

    bal_sqrt u_sqrt (
        .clk, .rst_n, .adv, .i_valid(sq_valid_reg), .i_last(sq_last_reg),
        .i_sq(sq_reg), .o_valid(rt_valid), .o_last(rt_last), .o_root(root)
    );

    logic [SUM_W-1:0] sum;
    assign sum = acc_reg + SUM_W'(root);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready) out_valid_reg <= 1'b0;
            if (adv && rt_valid)
            begin
                acc_reg <= rt_last ? '0 : sum;
                if (rt_last) out_valid_reg <= 1'b1;
            end
        end
    end
    always_ff @(posedge clk)
    begin
        if (adv && rt_valid && rt_last)
        begin
            sat_reg <= |sum[SUM_W-1:LEN_W];
            len_reg <= (|sum[SUM_W-1:LEN_W]) ? '1 : sum[LEN_W-1:0];
        end
    end

    assign out_valid  = out_valid_reg;
    assign arc_length = len_reg;
    assign saturated  = sat_reg;

    a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> arc_length == '1) else $error("sat len");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(arc_length))
        else $error("out hold");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready) else $error("busy");
endmodule
`default_nettype wire

@@ tb/sv/bezier_arc_length_tb.sv @@
// bezier_arc_length_tb: self-checking bench for the cubic Bezier arc length block.
// Depends on bal_pkg and bezier_arc_length; holds its own chord-sum predictor.
`timescale 1ns / 100ps
`default_nettype none
module bezier_arc_length_tb;
    import bal_pkg::*;

    localparam int  SEGS        = SEGMENTS;
    localparam int  NUM_RANDOM  = 1150;
    localparam int  CYCLE_LIMIT = 2_000_000;
    localparam int  END_WAIT    = SEGS + 40;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef coord_t curve_t [8];   // x1..x4, y1..y4

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic             sat;
    } length_t;

    // Draw modes for one coordinate.
    typedef enum int {DRAW_FULL, DRAW_SMALL, DRAW_EDGE, DRAW_NEAR} draw_t;

    // Receiver stall patterns.
    typedef enum int {RX_ALWAYS, RX_HALF, RX_SPARSE, RX_MOSTLY} rx_mode_t;

    logic   clk;
    logic   rst_n;
    logic   in_valid;
    logic   in_ready;
    coord_t start_x, ctrl1_x, ctrl2_x, end_x;
    coord_t start_y, ctrl1_y, ctrl2_y, end_y;
    logic   out_valid;
    logic   out_ready;
    logic [LEN_W-1:0] arc_length;
    logic   saturated;

    length_t  length_q[$];      // expected lengths, oldest first
    int       error_count;
    int       result_count;
    int       cycle_count;
    int       burst_left;
    int       hold_req;         // long receiver hold-off request, in cycles
    rx_mode_t rx_mode;

    bezier_arc_length uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .start_x    (start_x),
        .ctrl1_x    (ctrl1_x),
        .ctrl2_x    (ctrl2_x),
        .end_x      (end_x),
        .start_y    (start_y),
        .ctrl1_y    (ctrl1_y),
        .ctrl2_y    (ctrl2_y),
        .end_y      (end_y),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .arc_length (arc_length),
        .saturated  (saturated)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // floor(num / den), den > 0; SV division truncates toward zero
    function automatic longint floor_div(input longint num, input longint den);
        longint q;
        q = num / den;
        if ((num % den) != 0 && num < 0)
            q = q - 1;
        return q;
    endfunction

    // Curve point at t = k/SEGS, round to nearest with ties upward.
    function automatic longint curve_point(input longint p1, input longint a,
                                           input longint b, input longint c,
                                           input longint k);
        longint s3;
        longint num;
        s3  = longint'(SEGS) * SEGS * SEGS;
        num = a * (k * k * k) + b * (k * k * SEGS) + c * (k * SEGS * SEGS) + p1 * s3;
        return floor_div(num + s3 / 2, s3);
    endfunction

    // Integer square root, rounded to nearest (ties up).
    function automatic longint unsigned round_sqrt(input longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        longint unsigned rem;
        res  = 0;
        rem  = n;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (rem >= res + bitv)
            begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        if (rem > res)
            res = res + 1;
        return res;
    endfunction

    // Sum of SEGS chord lengths along the curve, saturating at 32 bits.
    function automatic length_t chord_sum(input curve_t cv);
        longint ax, bx, cx, ay, by, cy;
        longint px, py, nx, ny, dx, dy;
        longint unsigned total;
        length_t r;
        cx = 3 * (longint'(cv[1]) - longint'(cv[0]));
        bx = 3 * (longint'(cv[2]) - longint'(cv[1])) - cx;
        ax = longint'(cv[3]) - longint'(cv[0]) - cx - bx;
        cy = 3 * (longint'(cv[5]) - longint'(cv[4]));
        by = 3 * (longint'(cv[6]) - longint'(cv[5])) - cy;
        ay = longint'(cv[7]) - longint'(cv[4]) - cy - by;
        total = 0;
        px = curve_point(cv[0], ax, bx, cx, 0);
        py = curve_point(cv[4], ay, by, cy, 0);
        for (int k = 1; k <= SEGS; k++)
        begin
            nx = curve_point(cv[0], ax, bx, cx, k);
            ny = curve_point(cv[4], ay, by, cy, k);
            dx = nx - px;
            dy = ny - py;
            total = total + round_sqrt(longint'(dx * dx) + longint'(dy * dy));
            px = nx;
            py = ny;
        end
        if (total > 64'hFFFF_FFFF)
        begin
            r.len = '1;
            r.sat = 1'b1;
        end
        else
        begin
            r.len = total[LEN_W-1:0];
            r.sat = 1'b0;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Present one curve and hold it until the beat is taken. Valid stays
    // high on return so a back-to-back beat needs no second assignment.
    task automatic send_curve(input curve_t cv);
        start_x  <= cv[0];
        ctrl1_x  <= cv[1];
        ctrl2_x  <= cv[2];
        end_x    <= cv[3];
        start_y  <= cv[4];
        ctrl1_y  <= cv[5];
        ctrl2_y  <= cv[6];
        end_y    <= cv[7];
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        length_q.push_back(chord_sum(cv));
    endtask

    task automatic idle_input(input int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Bursty sender: after each burst, a random gap (sometimes none).
    task automatic send_bursty(input curve_t cv);
        send_curve(cv);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 12);
            if ($urandom_range(0, 3) != 0)
                idle_input($urandom_range(1, 90));
        end
    endtask

    task automatic wait_drained();
        idle_input(1);
        while (length_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic coord_t draw_coord(input draw_t mode);
        case (mode)
            DRAW_FULL:  return coord_t'($urandom);
            DRAW_SMALL: return coord_t'(int'($urandom_range(0, 16383)) - 8192);
            DRAW_EDGE:  return $urandom_range(0, 1) ? coord_t'(24'h7FFFFF)
                                                    : coord_t'(24'h800000);
            default:    return coord_t'(24'h7FFFFF - $urandom_range(0, 255)
                                        + ($urandom_range(0, 1) << 23));
        endcase
    endfunction

    function automatic curve_t random_curve();
        curve_t cv;
        draw_t  mode;
        mode = draw_t'($urandom_range(0, 3));
        for (int i = 0; i < 8; i++)
        begin
            // occasionally mix modes within one curve
            if ($urandom_range(0, 7) == 0)
                cv[i] = draw_coord(draw_t'($urandom_range(0, 3)));
            else
                cv[i] = draw_coord(mode);
        end
        return cv;
    endfunction

    // ------------------------------------------------------------------
    // Receiver and checker
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        $display("[%0t] mismatch on result %0d: %s got %0h expected %0h",
                 $realtime, result_count, what, got, want);
        error_count++;
    endtask

    // Checks each result beat against the oldest pending length.
    always @(posedge clk)
    begin
        length_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (length_q.size() == 0)
            begin
                $display("[%0t] result beat with nothing pending", $realtime);
                error_count++;
            end
            else
            begin
                want = length_q.pop_front();
                if (arc_length !== want.len)
                    report_mismatch("arc_length", arc_length, want.len);
                if (saturated !== want.sat)
                    report_mismatch("saturated", saturated, want.sat);
            end
            result_count++;
        end
    end

    // Ready pattern, switched to a new random mode when its run ends; a hold-off
    // request overrides it for a long stretch.
    initial
    begin
        int hold_left;
        int mode_left;
        hold_left = 0;
        mode_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req > 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (mode_left == 0)
            begin
                rx_mode   = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(50, 400);
            end
            else
                mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                case (rx_mode)
                    RX_ALWAYS: out_ready <= 1'b1;
                    RX_HALF:   out_ready <= $urandom_range(0, 1);
                    RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
                    default:   out_ready <= ($urandom_range(0, 9) != 0);
                endcase
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL bezier_arc_length");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Extremes, degenerate and straight curves, sign patterns.
    task automatic test_directed();
        curve_t cv;
        coord_t mx, mn;
        mx = 24'h7FFFFF;
        mn = 24'h800000;
        cv = '{default: 0};
        send_curve(cv);                                   // all points at origin
        cv = '{default: mx};
        send_curve(cv);
        cv = '{default: mn};
        send_curve(cv);
        cv = '{mn, mx, mn, mx, mn, mx, mn, mx};           // widest swings
        send_curve(cv);
        cv = '{mx, mn, mx, mn, mx, mn, mx, mn};
        send_curve(cv);
        cv = '{mn, mn, mx, mx, mn, mn, mx, mx};           // long diagonal
        send_curve(cv);
        cv = '{mn, mx, mx, mn, mx, mn, mn, mx};
        send_curve(cv);
        cv = '{0, 4096, 8192, 12288, 0, 0, 0, 0};         // straight line on x
        send_curve(cv);
        cv = '{0, 0, 0, 0, 0, 4096, 8192, 12288};         // straight line on y
        send_curve(cv);
        cv = '{0, 0, 0, 3, 0, 0, 0, 4};                   // sub-chord rounding
        send_curve(cv);
        cv = '{1, -1, 1, -1, -1, 1, -1, 1};
        send_curve(cv);
        cv = '{0, 0, 0, 0, 0, 0, 0, 1};                   // smallest move
        send_curve(cv);
        cv = '{-1, -1, -1, -1, -1, -1, -1, -1};
        send_curve(cv);
        cv = '{24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA,
               24'hAAAAAA, 24'h555555, 24'hAAAAAA, 24'h555555};
        send_curve(cv);
        cv = '{0, mx, mn, 0, 0, mn, mx, 0};               // closed loop
        send_curve(cv);
        wait_drained();
    endtask

    task automatic test_random_bursts(input int count);
        for (int i = 0; i < count; i++)
            send_bursty(random_curve());
    endtask

    // Receiver holds off long enough that the block backs up onto its input.
    task automatic test_output_backpressure();
        hold_req = 3000;
        for (int i = 0; i < 40; i++)
            send_curve(random_curve());
        wait_drained();
    endtask

    // Sender pauses on an empty pipe before going on.
    task automatic test_pause_on_drain();
        for (int i = 0; i < 20; i++)
            send_bursty(random_curve());
        wait_drained();
        for (int i = 0; i < 20; i++)
            send_curve(random_curve());
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        error_count  = 0;
        result_count = 0;
        cycle_count  = 0;
        burst_left   = 0;
        hold_req     = 0;
        rx_mode      = RX_ALWAYS;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        start_x      = '0;
        ctrl1_x      = '0;
        ctrl2_x      = '0;
        end_x        = '0;
        start_y      = '0;
        ctrl1_y      = '0;
        ctrl2_y      = '0;
        end_y        = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_output_backpressure();
        test_random_bursts(NUM_RANDOM / 2);
        test_pause_on_drain();
        test_random_bursts(NUM_RANDOM / 2);

        wait_drained();
        repeat (END_WAIT) @(posedge clk);
        if (error_count == 0)
            $display("PASS bezier_arc_length");
        else
            $display("FAIL bezier_arc_length");
        $finish;
    end
endmodule
`default_nettype wire
